[hdl/flth_pkg.sv]
// flth_pkg: shared types, constants and helpers for the fan level trip block
// no dependencies; imported by every module of the block
package flth_pkg;

  // field widths fixed by the interface
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned TEMP_W    = 20;
  localparam int unsigned STATUS_W  = 17;
  localparam int unsigned CODE_W    = 10;
  localparam int unsigned HYST_W    = 16;
  localparam int unsigned RANGE_W   = 12;
  localparam int unsigned DUTY8_W   = 8;
  localparam int unsigned DUTY_NUM_W = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned DEFAULT_NUM_LEVELS = 5;
  localparam int unsigned MAX_TRIP_LEVEL     = 4;

  // raw code conversion: temp = 450000 - 550 * code
  localparam logic [TEMP_W-1:0]   TEMP_OFFSET_MILLIC = 20'd450000;
  localparam logic [TEMP_W-1:0]   MILLIC_PER_CODE    = 20'd550;
  localparam logic [STATUS_W-1:0] VALID_MASK         = 17'h10400;
  localparam logic [STATUS_W-1:0] RAW_MASK           = 17'h003FF;

  // duty conversion: (duty255 * range + 127) / 255, divide by reciprocal
  localparam logic [DUTY_NUM_W-1:0] DUTY_ROUND  = 20'd127;
  localparam int unsigned           RECIP_W     = 21;
  localparam logic [RECIP_W-1:0]    RECIP_255   = 21'd1052689;
  localparam int unsigned           RECIP_SHIFT = 28;

  // register reset values
  localparam logic [TEMP_W-1:0]   RST_TRIP_ONE   = 20'd50000;
  localparam logic [TEMP_W-1:0]   RST_TRIP_TWO   = 20'd60000;
  localparam logic [TEMP_W-1:0]   RST_TRIP_THREE = 20'd67500;
  localparam logic [TEMP_W-1:0]   RST_TRIP_FOUR  = 20'd75000;
  localparam logic [HYST_W-1:0]   RST_HYST       = 16'd5000;
  localparam logic [RANGE_W-1:0]  RST_PWM_RANGE  = 12'd2078;
  localparam logic [LEVEL_W-1:0]  RST_SAFE_LEVEL = 3'd2;
  localparam logic [LEVEL_W-1:0]  RST_EXIT_FLOOR = 3'd1;

  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIP_ONE   = 3'd0,
    CFG_TRIP_TWO   = 3'd1,
    CFG_TRIP_THREE = 3'd2,
    CFG_TRIP_FOUR  = 3'd3,
    CFG_HYST       = 3'd4,
    CFG_PWM_RANGE  = 3'd5,
    CFG_SAFE_LEVEL = 3'd6,
    CFG_EXIT_FLOOR = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] sensor_status;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]       cool_level;
    logic [RANGE_W-1:0]       duty_ticks;
    logic                     commanded;
    logic                     reading_valid;
    logic signed [TEMP_W-1:0] temperature_millic;
  } result_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] trip_level_one;
    logic signed [TEMP_W-1:0] trip_level_two;
    logic signed [TEMP_W-1:0] trip_level_three;
    logic signed [TEMP_W-1:0] trip_level_four;
    logic [HYST_W-1:0]        hysteresis_millic;
    logic [RANGE_W-1:0]       pwm_range_ticks;
    logic [LEVEL_W-1:0]       safe_level;
    logic [LEVEL_W-1:0]       exit_floor_level;
  } cfg_t;

  // controller state carried from item to item
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               known;
    logic               stopped;
  } lvl_state_t;

  // decision stage output, waiting for the duty divide
  typedef struct packed {
    logic [LEVEL_W-1:0]       cool_level;
    logic [DUTY_NUM_W-1:0]    duty_num;
    logic                     commanded;
    logic                     reading_valid;
    logic signed [TEMP_W-1:0] temperature_millic;
  } dec_t;

  // duty out of 255 for each level
  function automatic logic [DUTY8_W-1:0] duty255(input logic [LEVEL_W-1:0] lvl);
    logic [DUTY8_W-1:0] d;
    case (lvl)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd75;
      3'd2:    d = 8'd125;
      3'd3:    d = 8'd175;
      default: d = 8'd250;
    endcase
    return d;
  endfunction

endpackage

[hdl/flth_cfg_regs.sv]
// flth_cfg_regs: configuration register file written by index
// depends on flth_pkg
module flth_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [flth_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [flth_pkg::CFG_DATA_W-1:0]   wr_data,
  output flth_pkg::cfg_t                    cfg
);
  import flth_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_level_one    <= RST_TRIP_ONE;
      cfg.trip_level_two    <= RST_TRIP_TWO;
      cfg.trip_level_three  <= RST_TRIP_THREE;
      cfg.trip_level_four   <= RST_TRIP_FOUR;
      cfg.hysteresis_millic <= RST_HYST;
      cfg.pwm_range_ticks   <= RST_PWM_RANGE;
      cfg.safe_level        <= RST_SAFE_LEVEL;
      cfg.exit_floor_level  <= RST_EXIT_FLOOR;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_TRIP_ONE:   cfg.trip_level_one    <= wr_data;
        CFG_TRIP_TWO:   cfg.trip_level_two    <= wr_data;
        CFG_TRIP_THREE: cfg.trip_level_three  <= wr_data;
        CFG_TRIP_FOUR:  cfg.trip_level_four   <= wr_data;
        CFG_HYST:       cfg.hysteresis_millic <= wr_data[HYST_W-1:0];
        CFG_PWM_RANGE:  cfg.pwm_range_ticks   <= wr_data[RANGE_W-1:0];
        CFG_SAFE_LEVEL: cfg.safe_level        <= wr_data[LEVEL_W-1:0];
        CFG_EXIT_FLOOR: cfg.exit_floor_level  <= wr_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/flth_decide.sv]
// flth_decide: level decision for one item (conversion, trip search, hysteresis)
// depends on flth_pkg; purely combinational, state held by the top level
module flth_decide #(
  parameter int unsigned NUM_LEVELS = flth_pkg::DEFAULT_NUM_LEVELS
) (
  input  flth_pkg::item_t      item,
  input  flth_pkg::lvl_state_t state,
  input  flth_pkg::cfg_t       cfg,
  output flth_pkg::lvl_state_t state_next,
  output flth_pkg::dec_t       dec
);
  import flth_pkg::*;

  localparam int unsigned TopInt =
      (NUM_LEVELS - 1 < MAX_TRIP_LEVEL) ? NUM_LEVELS - 1 : MAX_TRIP_LEVEL;
  localparam logic [LEVEL_W-1:0] TopLevel = LEVEL_W'(TopInt);

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
    return (lvl > TopLevel) ? TopLevel : lvl;
  endfunction

  function automatic logic signed [TEMP_W-1:0] trip_of(input cfg_t c,
                                                       input logic [LEVEL_W-1:0] lvl);
    logic signed [TEMP_W-1:0] t;
    case (lvl)
      3'd1:    t = c.trip_level_one;
      3'd2:    t = c.trip_level_two;
      3'd3:    t = c.trip_level_three;
      3'd4:    t = c.trip_level_four;
      default: t = '0;
    endcase
    return t;
  endfunction

  logic [CODE_W-1:0]        code;
  logic [TEMP_W-1:0]        code_scaled;
  logic signed [TEMP_W-1:0] temp;
  logic                     reading_ok;
  logic [LEVEL_W-1:0]       floor_lvl;
  logic [LEVEL_W-1:0]       safe_lvl;
  logic [LEVEL_W-1:0]       target;
  logic signed [TEMP_W+1:0] band_floor;
  logic signed [TEMP_W+1:0] temp_ext;
  logic signed [TEMP_W-1:0] cur_trip;

  assign code        = item.sensor_status[CODE_W-1:0];
  assign reading_ok  = (item.sensor_status & VALID_MASK) == VALID_MASK;
  assign code_scaled = TEMP_W'(code) * MILLIC_PER_CODE;
  // result always fits 20 bits signed, so modular subtract is exact
  assign temp        = $signed(TEMP_OFFSET_MILLIC - code_scaled);
  assign floor_lvl   = clamp_level(cfg.exit_floor_level);
  assign safe_lvl    = clamp_level(cfg.safe_level);
  assign cur_trip    = trip_of(cfg, state.level);
  assign temp_ext    = {{2{temp[TEMP_W-1]}}, temp};
  assign band_floor  = $signed({{2{cur_trip[TEMP_W-1]}}, cur_trip})
                     - $signed({6'd0, cfg.hysteresis_millic});

  always_comb begin
    state_next        = state;
    dec.commanded     = 1'b0;
    dec.reading_valid = 1'b0;
    dec.temperature_millic = '0;
    target            = '0;

    if (item.kind == KIND_END) begin
      state_next.stopped = 1'b1;
      if (!state.known || state.level < floor_lvl) begin
        state_next.level = floor_lvl;
        state_next.known = 1'b1;
        dec.commanded    = 1'b1;
      end
    end else if (!state.stopped) begin
      if (!reading_ok) begin
        if (!state.known || state.level < safe_lvl) begin
          state_next.level = safe_lvl;
          state_next.known = 1'b1;
          dec.commanded    = 1'b1;
        end
      end else begin
        dec.reading_valid      = 1'b1;
        dec.temperature_millic = temp;
        // highest usable level whose trip is reached
        for (int i = 1; i <= MAX_TRIP_LEVEL; i++) begin
          if (LEVEL_W'(i) <= TopLevel && temp >= trip_of(cfg, LEVEL_W'(i))) begin
            target = LEVEL_W'(i);
          end
        end
        // hold inside the band, else step down one level
        if (state.known && target < state.level) begin
          if (temp_ext >= band_floor) begin
            target = state.level;
          end else begin
            target = state.level - LEVEL_W'(1);
          end
        end
        if (!state.known || target != state.level) begin
          state_next.level = clamp_level(target);
          state_next.known = 1'b1;
          dec.commanded    = 1'b1;
        end
      end
    end

    dec.cool_level = state_next.known ? state_next.level : '0;
    dec.duty_num   = state_next.known
                   ? DUTY_NUM_W'(duty255(state_next.level)) * DUTY_NUM_W'(cfg.pwm_range_ticks)
                     + DUTY_ROUND
                   : '0;
  end

endmodule

[hdl/flth_duty_div.sv]
// flth_duty_div: divide the rounded duty numerator by 255
// depends on flth_pkg; reciprocal multiply, exact for numerators below 1.12e6
module flth_duty_div (
  input  logic [flth_pkg::DUTY_NUM_W-1:0] duty_num,
  output logic [flth_pkg::RANGE_W-1:0]    duty_ticks
);
  import flth_pkg::*;

  localparam int unsigned ProdW = DUTY_NUM_W + RECIP_W;

  logic [ProdW-1:0] prod;

  assign prod       = ProdW'(duty_num) * ProdW'(RECIP_255);
  assign duty_ticks = prod[RECIP_SHIFT +: RANGE_W];

endmodule

[hdl/fan_level_trip_hysteresis_core.sv]
// fan_level_trip_hysteresis_core: top level of the fan level trip controller
// depends on flth_pkg, flth_cfg_regs, flth_decide, flth_duty_div
// throughput: one request per cycle while the result channel is not stalled
// a three-stage pipeline (input register, decision register, result register) with the level
//   state updated as a request leaves stage one
// the duty divide by 255 is a reciprocal multiply that sits in the last stage
// reset (rst, synchronous): pipeline empty, level unknown, polling enabled, registers at defaults
module fan_level_trip_hysteresis_core #(
  parameter int unsigned NUM_LEVELS = flth_pkg::DEFAULT_NUM_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  flth_pkg::item_t                 item,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output flth_pkg::result_t               result,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [flth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flth_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import flth_pkg::*;

  // pipeline registers
  logic       s1_valid;
  item_t      s1_item;
  logic       s2_valid;
  dec_t       s2_dec;

  // controller state
  lvl_state_t state;
  lvl_state_t state_next;
  dec_t       dec;

  cfg_t              cfg;
  logic [RANGE_W-1:0] duty_ticks;

  // stage load enables; a stage loads when empty or when its contents move on
  logic s3_en;
  logic s2_en;
  logic s1_en;

  assign s3_en      = !result_valid || !result_stall;
  assign s2_en      = !s2_valid || s3_en;
  assign s1_en      = !s1_valid || s2_en;
  assign item_stall = !s1_en;

  // registers are always writable
  assign cfg_ready = 1'b1;

  flth_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // stage one: capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && item_valid) begin
      s1_item <= item;
    end
  end

  // decision on the captured request and the current state
  flth_decide #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_decide (
    .item       (s1_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .dec        (dec)
  );

  // state advances exactly when a request moves from stage one to stage two
  always_ff @(posedge clk) begin
    if (rst) begin
      state.level   <= '0;
      state.known   <= 1'b0;
      state.stopped <= 1'b0;
    end else if (s1_valid && s2_en) begin
      state <= state_next;
    end
  end

  // stage two: decision result
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      s2_dec <= dec;
    end
  end

  // duty conversion between stage two and the result register
  flth_duty_div u_duty (
    .duty_num   (s2_dec.duty_num),
    .duty_ticks (duty_ticks)
  );

  // stage three: result register, holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s3_en) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_valid) begin
      result.cool_level         <= s2_dec.cool_level;
      result.duty_ticks         <= duty_ticks;
      result.commanded          <= s2_dec.commanded;
      result.reading_valid      <= s2_dec.reading_valid;
      result.temperature_millic <= s2_dec.temperature_millic;
    end
  end

endmodule

[hdl/flth_checker.sv]
// flth_checker: port-level assertions for the fan level trip controller
// depends on flth_pkg; bound to fan_level_trip_hysteresis_core below
module flth_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input flth_pkg::result_t result
);
  import flth_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // level never exceeds the top trip level
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.cool_level <= LEVEL_W'(MAX_TRIP_LEVEL))
    else $error("fan level out of range");

  // level zero or no level means zero duty
  a_zero_duty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cool_level == '0 |-> result.duty_ticks == '0)
    else $error("nonzero duty at level zero");

  // temperature reported only with a valid reading
  a_temp_gated: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.reading_valid |-> result.temperature_millic == '0)
    else $error("temperature without a valid reading");

endmodule

bind fan_level_trip_hysteresis_core flth_checker u_flth_checker (.*);
